/* design/cttp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttp_pkg
// Shared types and constants of the circumcircle unit.
// ----------------------------------------------------------------------------
package cttp_pkg;

    // quotient bits kept by the divider, wider values saturate
    localparam int unsigned QUO_W    = 33;
    // result field width
    localparam int unsigned RES_W    = 32;
    // squared distance and its square root
    localparam int unsigned SQ_W     = 68;
    localparam int unsigned ROOT_W   = SQ_W / 2;
    // result transaction width, padded to whole bytes
    localparam int unsigned OUT_W    = 104;
    // result queue between front and back
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_AW     = 2;

    localparam logic [RES_W-1:0] C_MAX   = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] C_MIN   = 32'h8000_0000;
    localparam logic [RES_W-1:0] R_SAT   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    // queue status seen by both sides
    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    // center and flags carried through the radius stages
    typedef struct packed {
        logic signed [RES_W-1:0] cx;
        logic signed [RES_W-1:0] cy;
        logic                    sat;
        logic                    col;
    } t_circ;

endpackage

/* design/cttp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttp_front
// Input stage: chord differences, then the dot and determinant products.
// ----------------------------------------------------------------------------
module cttp_front import cttp_pkg::*; #(
    parameter int W     = 16,
    parameter int ENT_W = 18 * 16 + 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [6*W-1:0]     i_coords,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output logic [ENT_W-1:0]   o_entry
);

    localparam int DIF = W + 1;
    localparam int PW  = 2 * W + 2;

    typedef struct packed {
        logic signed [PW-1:0]  ga;
        logic signed [PW-1:0]  gb;
        logic signed [PW-1:0]  ea;
        logic signed [PW-1:0]  eb;
        logic signed [PW-1:0]  fc;
        logic signed [PW-1:0]  fd;
        logic signed [DIF-1:0] a;
        logic signed [DIF-1:0] b;
        logic signed [DIF-1:0] c;
        logic signed [DIF-1:0] d;
        logic signed [W-1:0]   x1;
        logic signed [W-1:0]   y1;
    } t_entry;

    logic signed [W-1:0]   w_x1, w_y1, w_x2, w_y2, w_x3, w_y3;
    logic                  w_adv1, w_adv2;
    logic                  r_f1_valid, r_f2_valid;
    logic signed [DIF-1:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [DIF-1:0] r1_sx2, r1_sy2, r1_sx3, r1_sy3, r1_ty, r1_tx;
    logic signed [W-1:0]   r1_x1, r1_y1;
    t_entry                r2_ent;

    // field unpacking, first point in the lowest bits
    assign w_x1 = i_coords[W-1:0];
    assign w_y1 = i_coords[2*W-1:W];
    assign w_x2 = i_coords[3*W-1:2*W];
    assign w_y2 = i_coords[4*W-1:3*W];
    assign w_x3 = i_coords[5*W-1:4*W];
    assign w_y3 = i_coords[6*W-1:5*W];

    // stall chain
    assign o_push  = r_f2_valid && !i_qstat.full;
    assign w_adv2  = !r_f2_valid || !i_qstat.full;
    assign w_adv1  = !r_f1_valid || w_adv2;
    assign o_ready = w_adv1;
    assign o_entry = r2_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_f1_valid <= i_valid;
            end
            if (w_adv2) begin
                r_f2_valid <= r_f1_valid;
            end
        end
    end

    // differences and sums
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_a   <= DIF'(w_x2) - DIF'(w_x1);
            r1_b   <= DIF'(w_y2) - DIF'(w_y1);
            r1_c   <= DIF'(w_x3) - DIF'(w_x1);
            r1_d   <= DIF'(w_y3) - DIF'(w_y1);
            r1_sx2 <= DIF'(w_x1) + DIF'(w_x2);
            r1_sy2 <= DIF'(w_y1) + DIF'(w_y2);
            r1_sx3 <= DIF'(w_x1) + DIF'(w_x3);
            r1_sy3 <= DIF'(w_y1) + DIF'(w_y3);
            r1_ty  <= DIF'(w_y3) - DIF'(w_y2);
            r1_tx  <= DIF'(w_x3) - DIF'(w_x2);
            r1_x1  <= w_x1;
            r1_y1  <= w_y1;
        end
    end

    // determinant and dot products
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_ent.ga <= PW'(r1_a * r1_ty);
            r2_ent.gb <= PW'(r1_b * r1_tx);
            r2_ent.ea <= PW'(r1_a * r1_sx2);
            r2_ent.eb <= PW'(r1_b * r1_sy2);
            r2_ent.fc <= PW'(r1_c * r1_sx3);
            r2_ent.fd <= PW'(r1_d * r1_sy3);
            r2_ent.a  <= r1_a;
            r2_ent.b  <= r1_b;
            r2_ent.c  <= r1_c;
            r2_ent.d  <= r1_d;
            r2_ent.x1 <= r1_x1;
            r2_ent.y1 <= r1_y1;
        end
    end

endmodule

/* design/cttp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttp_queue
// Short queue decoupling the front stages from the back pipeline.
// ----------------------------------------------------------------------------
module cttp_queue import cttp_pkg::*; #(
    parameter int ENT_W = 18 * 16 + 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [ENT_W-1:0] i_entry,
    input  logic             i_pop,
    output t_qstat           o_qstat,
    output logic [ENT_W-1:0] o_entry
);

    logic [ENT_W-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, r_rd;
    logic [Q_AW:0]    r_cnt;

    assign o_qstat.valid = (r_cnt != '0);
    assign o_qstat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_entry       = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* design/cttp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cttp_div import cttp_pkg::*; #(
    parameter int DEN_W = 37
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [DEN_W+QUO_W-1:0] i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic [QUO_W-1:0]       o_quo
);

    localparam int NPW = DEN_W + QUO_W;

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_nb  [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];

    assign o_quo = r_q[QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] w_prem;
        logic [QUO_W-1:0] w_pnb;
        logic [QUO_W-1:0] w_pq;
        logic [DEN_W-1:0] w_pden;
        logic [DEN_W:0]   w_t;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_prem = i_num[NPW-1:QUO_W];
            assign w_pnb  = i_num[QUO_W-1:0];
            assign w_pq   = '0;
            assign w_pden = i_den;
        end else begin : g_next
            assign w_prem = r_rem[k-1];
            assign w_pnb  = r_nb[k-1];
            assign w_pq   = r_q[k-1];
            assign w_pden = r_den[k-1];
        end

        // trial subtract of the divisor
        assign w_t    = {w_prem, w_pnb[QUO_W-1]};
        assign w_diff = w_t - {1'b0, w_pden};
        assign w_ge   = (w_t >= {1'b0, w_pden});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
                r_nb[k]  <= w_pnb << 1;
                r_q[k]   <= {w_pq[QUO_W-2:0], w_ge};
                r_den[k] <= w_pden;
            end
        end
    end

endmodule

/* design/cttp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttp_back
// Back pipeline: center numerators, rounded division, clamping, radius root.
// ----------------------------------------------------------------------------
module cttp_back import cttp_pkg::*; #(
    parameter int W     = 16,
    parameter int ENT_W = 18 * 16 + 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qstat           i_qstat,
    input  logic [ENT_W-1:0] i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_cx,
    output logic [RES_W-1:0] o_cy,
    output logic [RES_W-1:0] o_radius,
    output t_status          o_status
);

    localparam int DIF = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int EFW = 2 * W + 3;
    localparam int GW  = 2 * W + 4;
    localparam int LH  = W + 2;
    localparam int HW  = EFW - LH;
    localparam int LPW = DIF + LH + 1;
    localparam int HPW = DIF + HW;
    localparam int NXW = 3 * W + 5;
    localparam int NW  = 3 * W + 6;
    localparam int DW  = 2 * W + 5;
    localparam int NPW = DW + QUO_W;
    localparam int SW  = QUO_W + 1;
    localparam int LAT = 11 + QUO_W + ROOT_W;
    localparam logic [QUO_W-1:0] Q_HALF = QUO_W'(64'h8000_0000);

    typedef struct packed {
        logic signed [PW-1:0]  ga;
        logic signed [PW-1:0]  gb;
        logic signed [PW-1:0]  ea;
        logic signed [PW-1:0]  eb;
        logic signed [PW-1:0]  fc;
        logic signed [PW-1:0]  fd;
        logic signed [DIF-1:0] a;
        logic signed [DIF-1:0] b;
        logic signed [DIF-1:0] c;
        logic signed [DIF-1:0] d;
        logic signed [W-1:0]   x1;
        logic signed [W-1:0]   y1;
    } t_entry;

    typedef struct packed {
        logic                ovfx;
        logic                ovfy;
        logic                negx;
        logic                negy;
        logic                col;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
    } t_side;

    // signed quotient with clamp to 32 bits, flag in the top bit
    function automatic logic [RES_W:0] f_clamp(input logic [QUO_W-1:0] q,
                                               input logic neg, input logic ovf);
        logic [SW-1:0] v;
        logic          sat;
        v   = neg ? SW'(-{1'b0, q}) : SW'({1'b0, q});
        sat = ovf || (neg ? (q > Q_HALF) : (q >= Q_HALF));
        if (sat) begin
            f_clamp = {1'b1, neg ? C_MIN : C_MAX};
        end else begin
            f_clamp = {1'b0, v[RES_W-1:0]};
        end
    endfunction

    t_entry                w_ent;
    logic                  w_adv;
    logic [LAT-1:0]        r_vp;

    logic signed [EFW-1:0] r0_e, r0_f;
    logic signed [GW-1:0]  r0_g;
    logic                  r0_col;
    logic signed [DIF-1:0] r0_a, r0_b, r0_c, r0_d;
    logic signed [W-1:0]   r0_x1, r0_y1;

    logic [LH-1:0]         w_elo, w_flo;
    logic signed [HW-1:0]  w_ehi, w_fhi;
    logic signed [LPW-1:0] r1_delo, r1_bflo, r1_aflo, r1_celo;
    logic signed [HPW-1:0] r1_dehi, r1_bfhi, r1_afhi, r1_cehi;
    logic signed [GW-1:0]  r1_g;
    logic                  r1_col;
    logic signed [W-1:0]   r1_x1, r1_y1;

    logic signed [NXW-1:0] r2_nx, r2_ny;
    logic signed [GW-1:0]  r2_g;
    logic                  r2_col;
    logic signed [W-1:0]   r2_x1, r2_y1;

    logic [NXW-1:0]        w_anx, w_any;
    logic [GW-1:0]         w_ag;
    logic [NW-1:0]         r3_numx, r3_numy;
    logic [DW-1:0]         r3_den;
    logic                  r3_negx, r3_negy, r3_col;
    logic signed [W-1:0]   r3_x1, r3_y1;

    logic [NPW-1:0]        w_nx3, w_ny3, w_dsh;
    logic [NPW-1:0]        r4_numx, r4_numy;
    logic [DW-1:0]         r4_den;
    t_side                 r4_side;
    t_side                 r_dl [QUO_W];
    logic [QUO_W-1:0]      w_qx, w_qy;

    logic [RES_W:0]        w_clx, w_cly;
    t_circ                 r5_c;
    logic signed [W-1:0]   r5_x1, r5_y1;

    logic signed [SW-1:0]  w_dx, w_dy;
    logic [QUO_W-1:0]      r6_adx, r6_ady;
    t_circ                 r6_c;

    logic [33:0]           r7_hhx, r7_hhy;
    logic [32:0]           r7_hlx, r7_hly;
    logic [31:0]           r7_llx, r7_lly;
    t_circ                 r7_c;

    logic [SQ_W-1:0]       r8_sqx, r8_sqy;
    t_circ                 r8_c;
    logic [SQ_W-1:0]       r9_s;
    t_circ                 r9_c;

    logic [ROOT_W+1:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0]     r_root [ROOT_W];
    logic [SQ_W-1:0]       r_sv   [ROOT_W];
    t_circ                 r_rc   [ROOT_W];

    logic [ROOT_W-1:0]     w_root;
    logic [ROOT_W+1:0]     w_rem;
    logic [ROOT_W:0]       w_rad;
    logic                  w_rovf;
    t_circ                 w_fc;
    logic [RES_W-1:0]      r_cx, r_cy, r_rad;
    t_status               r_status;

    // global advance, a single output register at the end
    assign w_ent   = i_entry;
    assign w_adv   = !r_vp[LAT-1] || i_ready;
    assign o_pop   = w_adv && i_qstat.valid;
    assign o_valid = r_vp[LAT-1];
    assign o_cx     = r_cx;
    assign o_cy     = r_cy;
    assign o_radius = r_rad;
    assign o_status = r_status;

    // occupancy of each stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (w_adv) begin
            r_vp <= {r_vp[LAT-2:0], i_qstat.valid};
        end
    end

    // dot terms, determinant, collinear test
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_e   <= EFW'(w_ent.ea) + EFW'(w_ent.eb);
            r0_f   <= EFW'(w_ent.fc) + EFW'(w_ent.fd);
            r0_g   <= (GW'(w_ent.ga) - GW'(w_ent.gb)) <<< 1;
            r0_col <= (w_ent.ga == w_ent.gb);
            r0_a   <= w_ent.a;
            r0_b   <= w_ent.b;
            r0_c   <= w_ent.c;
            r0_d   <= w_ent.d;
            r0_x1  <= w_ent.x1;
            r0_y1  <= w_ent.y1;
        end
    end

    // numerator partial products, dot terms split in two halves
    assign w_elo = r0_e[LH-1:0];
    assign w_ehi = r0_e[EFW-1:LH];
    assign w_flo = r0_f[LH-1:0];
    assign w_fhi = r0_f[EFW-1:LH];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_delo <= LPW'(r0_d * $signed({1'b0, w_elo}));
            r1_bflo <= LPW'(r0_b * $signed({1'b0, w_flo}));
            r1_aflo <= LPW'(r0_a * $signed({1'b0, w_flo}));
            r1_celo <= LPW'(r0_c * $signed({1'b0, w_elo}));
            r1_dehi <= HPW'(r0_d * w_ehi);
            r1_bfhi <= HPW'(r0_b * w_fhi);
            r1_afhi <= HPW'(r0_a * w_fhi);
            r1_cehi <= HPW'(r0_c * w_ehi);
            r1_g    <= r0_g;
            r1_col  <= r0_col;
            r1_x1   <= r0_x1;
            r1_y1   <= r0_y1;
        end
    end

    // center numerators
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_nx  <= (NXW'(r1_dehi) <<< LH) + NXW'(r1_delo)
                    - (NXW'(r1_bfhi) <<< LH) - NXW'(r1_bflo);
            r2_ny  <= (NXW'(r1_afhi) <<< LH) + NXW'(r1_aflo)
                    - (NXW'(r1_cehi) <<< LH) - NXW'(r1_celo);
            r2_g   <= r1_g;
            r2_col <= r1_col;
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;
        end
    end

    // magnitudes, rounding offset, quotient signs
    assign w_anx = r2_nx[NXW-1] ? NXW'(-r2_nx) : NXW'(r2_nx);
    assign w_any = r2_ny[NXW-1] ? NXW'(-r2_ny) : NXW'(r2_ny);
    assign w_ag  = r2_g[GW-1] ? GW'(-r2_g) : GW'(r2_g);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_numx <= (NW'(w_anx) << 1) + NW'(w_ag);
            r3_numy <= (NW'(w_any) << 1) + NW'(w_ag);
            r3_den  <= DW'(w_ag) << 1;
            r3_negx <= r2_nx[NXW-1] ^ r2_g[GW-1];
            r3_negy <= r2_ny[NXW-1] ^ r2_g[GW-1];
            r3_col  <= r2_col;
            r3_x1   <= r2_x1;
            r3_y1   <= r2_y1;
        end
    end

    // quotients too wide for the divider saturate
    assign w_nx3 = NPW'(r3_numx);
    assign w_ny3 = NPW'(r3_numy);
    assign w_dsh = {r3_den, {QUO_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_numx      <= w_nx3;
            r4_numy      <= w_ny3;
            r4_den       <= r3_den;
            r4_side.ovfx <= (w_nx3 >= w_dsh);
            r4_side.ovfy <= (w_ny3 >= w_dsh);
            r4_side.negx <= r3_negx;
            r4_side.negy <= r3_negy;
            r4_side.col  <= r3_col;
            r4_side.x1   <= r3_x1;
            r4_side.y1   <= r3_y1;
        end
    end

    cttp_div #(.DEN_W(DW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r4_numx),
        .i_den (r4_den),
        .o_quo (w_qx)
    );

    cttp_div #(.DEN_W(DW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r4_numy),
        .i_den (r4_den),
        .o_quo (w_qy)
    );

    // sideband delay matching the divider
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl[0] <= r4_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // sign and clamp of the center
    assign w_clx = f_clamp(w_qx, r_dl[QUO_W-1].negx, r_dl[QUO_W-1].ovfx);
    assign w_cly = f_clamp(w_qy, r_dl[QUO_W-1].negy, r_dl[QUO_W-1].ovfy);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_c.cx  <= w_clx[RES_W-1:0];
            r5_c.cy  <= w_cly[RES_W-1:0];
            r5_c.sat <= w_clx[RES_W] | w_cly[RES_W];
            r5_c.col <= r_dl[QUO_W-1].col;
            r5_x1    <= r_dl[QUO_W-1].x1;
            r5_y1    <= r_dl[QUO_W-1].y1;
        end
    end

    // distance from the first point
    assign w_dx = SW'(r5_x1) - SW'(r5_c.cx);
    assign w_dy = SW'(r5_y1) - SW'(r5_c.cy);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_adx <= w_dx[SW-1] ? QUO_W'(-w_dx) : QUO_W'(w_dx);
            r6_ady <= w_dy[SW-1] ? QUO_W'(-w_dy) : QUO_W'(w_dy);
            r6_c   <= r5_c;
        end
    end

    // squares from 17 by 16 bit halves
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_hhx <= 34'(r6_adx[32:16] * r6_adx[32:16]);
            r7_hlx <= 33'(r6_adx[32:16] * r6_adx[15:0]);
            r7_llx <= 32'(r6_adx[15:0] * r6_adx[15:0]);
            r7_hhy <= 34'(r6_ady[32:16] * r6_ady[32:16]);
            r7_hly <= 33'(r6_ady[32:16] * r6_ady[15:0]);
            r7_lly <= 32'(r6_ady[15:0] * r6_ady[15:0]);
            r7_c   <= r6_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_sqx <= (SQ_W'(r7_hhx) << 32) + (SQ_W'(r7_hlx) << 17) + SQ_W'(r7_llx);
            r8_sqy <= (SQ_W'(r7_hhy) << 32) + (SQ_W'(r7_hly) << 17) + SQ_W'(r7_lly);
            r8_c   <= r7_c;
            r9_s   <= r8_sqx + r8_sqy;
            r9_c   <= r8_c;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        logic [ROOT_W+1:0] w_prem;
        logic [ROOT_W-1:0] w_proot;
        logic [SQ_W-1:0]   w_ps;
        t_circ             w_pc;
        logic [ROOT_W+3:0] w_t;
        logic [ROOT_W+3:0] w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_prem  = '0;
            assign w_proot = '0;
            assign w_ps    = r9_s;
            assign w_pc    = r9_c;
        end else begin : g_next
            assign w_prem  = r_rem[j-1];
            assign w_proot = r_root[j-1];
            assign w_ps    = r_sv[j-1];
            assign w_pc    = r_rc[j-1];
        end

        assign w_t     = {w_prem, w_ps[SQ_W-1-2*j -: 2]};
        assign w_trial = {2'b00, w_proot, 2'b01};
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[j]  <= w_ge ? (ROOT_W+2)'(w_t - w_trial) : (ROOT_W+2)'(w_t);
                r_root[j] <= {w_proot[ROOT_W-2:0], w_ge};
                r_sv[j]   <= w_ps;
                r_rc[j]   <= w_pc;
            end
        end
    end

    // round to nearest and format the result
    assign w_root = r_root[ROOT_W-1];
    assign w_rem  = r_rem[ROOT_W-1];
    assign w_fc   = r_rc[ROOT_W-1];
    assign w_rad  = (ROOT_W+1)'(w_root) + (ROOT_W+1)'(w_rem > (ROOT_W+2)'(w_root));
    assign w_rovf = |w_rad[ROOT_W:RES_W];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_fc.col) begin
                r_cx     <= '0;
                r_cy     <= '0;
                r_rad    <= '0;
                r_status <= ST_COLLINEAR;
            end else if (w_fc.sat || w_rovf) begin
                r_cx     <= w_fc.cx;
                r_cy     <= w_fc.cy;
                r_rad    <= R_SAT;
                r_status <= ST_SATURATED;
            end else begin
                r_cx     <= w_fc.cx;
                r_cy     <= w_fc.cy;
                r_rad    <= w_rad[RES_W-1:0];
                r_status <= ST_VALID;
            end
        end
    end

endmodule

/* design/circle_through_three_points_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_through_three_points_unit
// Circumcircle of three fixed-point points: center and rounded radius.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel i_s_*: one transaction carries three points, six signed
//   coordinates of COORD_WIDTH bits. Master channel o_m_*: one transaction
//   per input with center x, center y, radius and a status code (valid,
//   collinear points, saturated).
//   Throughput: one transaction per cycle while the master side is ready.
//   The pipeline depth is set mostly by the 33 stages of the two parallel
//   center dividers and the 34 stages of the radius square root, one
//   result bit per stage each.
//   A two-stage front computes chord differences and products, then a
//   four-entry queue feeds the back pipeline, so the input side keeps
//   taking transactions while the back pipeline is held.
//   When the receiver stalls, the back pipeline holds as a whole, the queue
//   fills and then o_s_tready drops.
//   Reset clears all valid flags and queue pointers; no result is pending
//   after reset.
// ----------------------------------------------------------------------------
module circle_through_three_points_unit import cttp_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    localparam int IN_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // center_x, center_y, radius, status
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int ENT_W = 18 * COORD_WIDTH + 16;

    t_qstat             w_qstat;
    logic               w_push, w_pop;
    logic [ENT_W-1:0]   w_fent, w_qent;
    logic [RES_W-1:0]   w_cx, w_cy, w_rad;
    t_status            w_status;

    cttp_front #(.W(COORD_WIDTH), .ENT_W(ENT_W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_coords (i_s_tdata[6*COORD_WIDTH-1:0]),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_entry  (w_fent)
    );

    cttp_queue #(.ENT_W(ENT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_fent),
        .i_pop   (w_pop),
        .o_qstat (w_qstat),
        .o_entry (w_qent)
    );

    cttp_back #(.W(COORD_WIDTH), .ENT_W(ENT_W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_entry  (w_qent),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_cx     (w_cx),
        .o_cy     (w_cy),
        .o_radius (w_rad),
        .o_status (w_status)
    );

    // result packing, center x in the lowest bits
    assign o_m_tdata = {{(OUT_W - 3 * RES_W - 2){1'b0}}, w_status, w_rad, w_cy, w_cx};

    // collinear points give an all-zero circle
    a_collinear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_status == ST_COLLINEAR) |-> (o_m_tdata[3*RES_W-1:0] == '0))
        else $error("collinear result with nonzero circle");

    // saturation always reports the full radius
    a_sat_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_status == ST_SATURATED) |-> (w_rad == R_SAT))
        else $error("saturated result without full radius");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full && !w_pop |=> !($past(w_push)) || w_qstat.full)
        else $error("queue push while full");

endmodule

/* test/circle_through_three_points_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_through_three_points_unit_test
// Self-checking bench for the circumcircle unit: random and corner point
// triples are streamed in, each result is compared with a local predictor.
// ----------------------------------------------------------------------------
module circle_through_three_points_unit_test;
    import cttp_pkg::*;

    localparam int CW   = 16;
    localparam int IN_W = ((6 * CW + 7) / 8) * 8;

    typedef struct {
        logic signed [RES_W-1:0] cx;
        logic signed [RES_W-1:0] cy;
        logic [RES_W-1:0]        rad;
        t_status                 st;
    } t_circle;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    logic [IN_W-1:0] triple_q[$];
    t_circle         circle_q[$];
    int              n_err = 0;
    int              n_out = 0;
    bit              all_queued = 1'b0;
    bit              calm = 1'b0;
    int              send_gap = 0;
    int              recv_gap = 0;
    int              hold_cnt = 0;

    circle_through_three_points_unit #(.COORD_WIDTH(CW)) dut (.*);

    always #2 i_clk = ~i_clk;

    // rounded signed quotient, ties away from zero
    function automatic logic signed [127:0] round_quot(logic signed [127:0] n,
                                                       logic signed [127:0] g);
        logic [127:0] na, ga, q;
        na = n < 0 ? -n : n;
        ga = g < 0 ? -g : g;
        q  = (2 * na + ga) / (2 * ga);
        return ((n < 0) != (g < 0)) ? -$signed(q) : $signed(q);
    endfunction

    // square root rounded to nearest
    function automatic logic [127:0] root_nearest(logic [127:0] s);
        logic [127:0] r, b;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= s) r = b;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic t_circle circumcircle(logic [IN_W-1:0] t);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, a, b, c, d, e, f, g, cx, cy, dx, dy;
        logic [127:0] rad;
        t_circle o;
        x1 = $signed(t[0*CW +: CW]); y1 = $signed(t[1*CW +: CW]);
        x2 = $signed(t[2*CW +: CW]); y2 = $signed(t[3*CW +: CW]);
        x3 = $signed(t[4*CW +: CW]); y3 = $signed(t[5*CW +: CW]);
        a = x2 - x1; b = y2 - y1; c = x3 - x1; d = y3 - y1;
        e = a * (x1 + x2) + b * (y1 + y2);
        f = c * (x1 + x3) + d * (y1 + y3);
        g = 2 * (a * (y3 - y2) - b * (x3 - x2));
        if (g == 0) begin
            o.cx = 0; o.cy = 0; o.rad = 0; o.st = ST_COLLINEAR;
            return o;
        end
        cx = round_quot(d * e - b * f, g);
        cy = round_quot(a * f - c * e, g);
        if (cx > 128'sh7FFF_FFFF || cx < -128'sh8000_0000
                || cy > 128'sh7FFF_FFFF || cy < -128'sh8000_0000) begin
            o.cx = cx > 128'sh7FFF_FFFF ? C_MAX : cx < -128'sh8000_0000 ? C_MIN : cx[31:0];
            o.cy = cy > 128'sh7FFF_FFFF ? C_MAX : cy < -128'sh8000_0000 ? C_MIN : cy[31:0];
            o.rad = R_SAT; o.st = ST_SATURATED;
            return o;
        end
        o.cx = cx[31:0]; o.cy = cy[31:0];
        dx = x1 - cx; dy = y1 - cy;
        rad = root_nearest(dx * dx + dy * dy);
        if (rad > 128'hFFFF_FFFF) begin
            o.rad = R_SAT; o.st = ST_SATURATED;
        end else begin
            o.rad = rad[31:0]; o.st = ST_VALID;
        end
        return o;
    endfunction

    function automatic logic [IN_W-1:0] pack_pts(int x1, int y1, int x2, int y2,
                                                 int x3, int y3);
        logic [IN_W-1:0] t;
        t = '0;
        t[0*CW +: CW] = x1[CW-1:0]; t[1*CW +: CW] = y1[CW-1:0];
        t[2*CW +: CW] = x2[CW-1:0]; t[3*CW +: CW] = y2[CW-1:0];
        t[4*CW +: CW] = x3[CW-1:0]; t[5*CW +: CW] = y3[CW-1:0];
        return t;
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span, 0) - span;
    endfunction

    // stimulus: corners, then mostly moderate triples with some full-range, collinear and thin ones
    initial begin
        logic [IN_W-1:0] t;
        triple_q.push_back(pack_pts(0, 0, 256, 0, 0, 256));
        triple_q.push_back(pack_pts(0, 0, 0, 0, 0, 0));
        triple_q.push_back(pack_pts(0, 0, 100, 100, 200, 200));
        triple_q.push_back(pack_pts(5, 5, 5, 5, 300, -7));
        triple_q.push_back(pack_pts(-32768, -32768, 32767, -32768, -32768, 32767));
        triple_q.push_back(pack_pts(32767, 32767, -32768, 32767, 32767, -32768));
        triple_q.push_back(pack_pts(-32768, -32768, 32767, 32767, -32768, 32767));
        triple_q.push_back(pack_pts(0, 0, 1, 0, 0, 1));
        triple_q.push_back(pack_pts(0, 0, 1, 1, 2, 3));
        triple_q.push_back(pack_pts(-32768, 0, 32767, 1, 0, 2));
        triple_q.push_back(pack_pts(0, 0, 32767, 1, -32768, 0));
        triple_q.push_back(pack_pts(1, 1, -1, -1, 1, -1));
        triple_q.push_back(pack_pts(-1, -1, -1, -1, -1, -1));
        triple_q.push_back(pack_pts(-32768, -32768, -32768, 32767, 32767, 0));
        triple_q.push_back(pack_pts(1000, -2000, 1001, -1999, 1003, -1996));
        for (int i = 0; i < 400; i++) begin
            case ($urandom_range(9, 0))
                0, 1: t = {$urandom, $urandom, $urandom};
                2: begin
                    int px, py, qx, qy, k;
                    px = rnd_coord(1000); py = rnd_coord(1000);
                    qx = rnd_coord(30); qy = rnd_coord(30);
                    k = $urandom_range(20, 1);
                    t = pack_pts(px, py, px + qx, py + qy, px - k * qx, py - k * qy);
                end
                3: begin
                    int px, py;
                    px = rnd_coord(32768 - 200); py = rnd_coord(32768 - 200);
                    t = pack_pts(px, py, px + $urandom_range(3, 1), py,
                                 px + rnd_coord(5), py + rnd_coord(150));
                end
                default: t = pack_pts(rnd_coord(8000), rnd_coord(8000),
                                      rnd_coord(8000), rnd_coord(8000),
                                      rnd_coord(8000), rnd_coord(8000));
            endcase
            triple_q.push_back(t);
        end
        all_queued = 1'b1;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender: offers triples with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            logic busy;
            busy = i_s_tvalid && !o_s_tready;
            if (i_s_tvalid && o_s_tready) circle_q.push_back(circumcircle(i_s_tdata));
            calm <= triple_q.size() < 60;
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (triple_q.size() > 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= triple_q.pop_front();
                    if (!calm && $urandom_range(7, 0) == 0) send_gap <= $urandom_range(14, 1);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off early on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (n_out >= 20 && hold_cnt < 300) begin
            hold_cnt   <= hold_cnt + 1;
            i_m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(7, 0) == 0) recv_gap <= $urandom_range(14, 1);
        end
    end

    // monitor: compares each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_circle want;
            logic [31:0] gx, gy, gr;
            logic [1:0]  gs;
            gx = o_m_tdata[31:0]; gy = o_m_tdata[63:32];
            gr = o_m_tdata[95:64]; gs = o_m_tdata[97:96];
            n_out <= n_out + 1;
            if (circle_q.size() == 0) begin
                n_err <= n_err + 1;
                if (n_err < 10) $display("unexpected result %h", o_m_tdata);
            end else begin
                want = circle_q.pop_front();
                if (gx !== want.cx || gy !== want.cy || gr !== want.rad || gs !== want.st) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("mismatch: exp cx=%h cy=%h r=%h st=%0d got cx=%h cy=%h r=%h st=%0d",
                                 want.cx, want.cy, want.rad, want.st, gx, gy, gr, gs);
                end
            end
        end
    end

    initial begin
        wait (all_queued && triple_q.size() == 0 && i_rst_n);
        @(posedge i_clk);
        while (i_s_tvalid || circle_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_err == 0 && circle_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
